// ===== design/accel_tilt_roll_pitch_assert.svh =====
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch_assert.svh
// Assertion macros for the tilt block; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_ROLL_PITCH_ASSERT_SVH
`define ACCEL_TILT_ROLL_PITCH_ASSERT_SVH
`ifndef SYNTHESIS
// check on every clock edge outside reset
`define ATRP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("accel_tilt_roll_pitch assertion failed");
// check on every clock edge, reset included
`define ATRP_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("accel_tilt_roll_pitch reset assertion failed");
`else
`define ATRP_ASSERT(lbl, prop)
`define ATRP_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== design/atrp_pkg.sv =====
// ----------------------------------------------------------------------------
// atrp_pkg
// Shared constants, types and the arctangent table for the tilt pipeline.
// ----------------------------------------------------------------------------
package atrp_pkg;

	// rotation count and output fraction bits
	localparam int CORDIC_STAGES   = 16;
	localparam int ANGLE_FRAC_BITS = 8;
	localparam int ATAN_TABLE_LEN  = 24;
	localparam int NUM_STAGES      = (CORDIC_STAGES < ATAN_TABLE_LEN) ?
		CORDIC_STAGES : ATAN_TABLE_LEN;

	// field widths
	localparam int AXIS_W  = 16;
	localparam int ROLL_W  = 17;
	localparam int PITCH_W = 16;
	localparam int DEG_W   = 17;

	// magnitude path: root of (y*y + z*z) * 2^16, 8 fraction bits
	localparam int SQ_W         = 32;
	localparam int MAG_FRAC     = 8;
	localparam int RAD_W        = SQ_W + 2 * MAG_FRAC;
	localparam int ROOT_W       = RAD_W / 2;
	localparam int ISQRT_STAGES = ROOT_W;

	// rotator widths
	localparam int AW        = ROOT_W + 1;
	localparam int PRE_SHIFT = 24;
	localparam int CW        = 52;
	localparam int ZW        = 34;
	localparam longint Q30_HALF_PI = 64'sd1686629713;

	// radians to degrees: times 573, divided by 10 * 2^ROUND_SHIFT
	localparam int DEG_SCALE   = 573;
	localparam int NUM_W       = ZW + 11;
	localparam int ROUND_SHIFT = 30 - ANGLE_FRAC_BITS;
	localparam int T_W         = 12 + ANGLE_FRAC_BITS;
	localparam int DIV10_K     = 28;
	localparam int DIV10_M_W   = 25;
	localparam longint DIV10_M = ((64'd1 << DIV10_K) + 64'd9) / 64'd10;
	localparam int PROD_W      = T_W + DIV10_M_W;

	localparam int ROLL_LIM  = 180 << ANGLE_FRAC_BITS;
	localparam int PITCH_LIM = 90 << ANGLE_FRAC_BITS;

	// stage count of one rotator plus conversion, and of the whole pipeline
	localparam int DEG_LAT    = NUM_STAGES + 5;
	localparam int PIPE_DEPTH = 2 + ISQRT_STAGES + DEG_LAT;

	typedef logic signed [AW-1:0]    vec_t;
	typedef logic signed [CW-1:0]    rot_t;
	typedef logic signed [ZW-1:0]    ang_t;
	typedef logic signed [DEG_W-1:0] deg_t;
	typedef logic [ROOT_W-1:0]       root_t;

	// atan(2^-i) in Q30 radians
	function automatic ang_t atan_q30(input int idx);
		ang_t v;
		case (idx)
			0: v = 34'sd843314857;
			1: v = 34'sd497837830;
			2: v = 34'sd263043837;
			3: v = 34'sd133525159;
			4: v = 34'sd67021687;
			5: v = 34'sd33543516;
			6: v = 34'sd16775851;
			7: v = 34'sd8388437;
			8: v = 34'sd4194283;
			9: v = 34'sd2097149;
			10: v = 34'sd1048576;
			11: v = 34'sd524288;
			12: v = 34'sd262144;
			13: v = 34'sd131072;
			14: v = 34'sd65536;
			15: v = 34'sd32768;
			16: v = 34'sd16384;
			17: v = 34'sd8192;
			18: v = 34'sd4096;
			19: v = 34'sd2048;
			20: v = 34'sd1024;
			21: v = 34'sd512;
			22: v = 34'sd256;
			23: v = 34'sd128;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== design/atrp_isqrt.sv =====
// ----------------------------------------------------------------------------
// atrp_isqrt
// Pipelined floor square root of sq * 2^16, one root bit per stage.
// ----------------------------------------------------------------------------
module atrp_isqrt (
	input  logic                         clk,
	input  logic                         adv,
	input  logic [atrp_pkg::SQ_W-1:0]    sq,
	output logic [atrp_pkg::ROOT_W-1:0]  root
);
	import atrp_pkg::*;

	logic [RAD_W-1:0]  rem_s  [0:ISQRT_STAGES-1];
	logic [ROOT_W-1:0] root_s [0:ISQRT_STAGES-1];

	// one restoring step per stage, root bit ROOT_W-1-k in stage k
	for (genvar k = 0; k < ISQRT_STAGES; k++) begin : g_step
		localparam int M = ISQRT_STAGES - 1 - k;
		logic [RAD_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  trial;

		if (k == 0) begin : g_first
			assign rem_in  = {sq, {(2 * MAG_FRAC){1'b0}}};
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign trial = (RAD_W'(root_in) << (M + 1)) | (RAD_W'(1) << (2 * M));

		always_ff @(posedge clk) begin
			if (adv) begin
				if (rem_in >= trial) begin
					rem_s[k]  <= rem_in - trial;
					root_s[k] <= root_in | (ROOT_W'(1) << M);
				end else begin
					rem_s[k]  <= rem_in;
					root_s[k] <= root_in;
				end
			end
		end
	end

	assign root = root_s[ISQRT_STAGES-1];

endmodule

// ===== design/atrp_atan_deg.sv =====
// ----------------------------------------------------------------------------
// atrp_atan_deg
// Vectoring rotator for atan2(a, b) followed by a four-stage degree scaler.
// ----------------------------------------------------------------------------
module atrp_atan_deg (
	input  logic                        clk,
	input  logic                        adv,
	input  atrp_pkg::vec_t              a,
	input  atrp_pkg::vec_t              b,
	input  logic [atrp_pkg::DEG_W-1:0]  lim,
	output atrp_pkg::deg_t              deg
);
	import atrp_pkg::*;

	rot_t x_s    [0:NUM_STAGES];
	rot_t y_s    [0:NUM_STAGES];
	ang_t z_s    [0:NUM_STAGES];
	logic zero_s [0:NUM_STAGES];

	vec_t pre_x;
	vec_t pre_y;
	ang_t pre_z;
	rot_t pre_xe;
	rot_t pre_ye;

	// turn the left half plane by a quarter turn
	always_comb begin
		pre_x = b;
		pre_y = a;
		pre_z = '0;
		if (b[AW-1]) begin
			if (!a[AW-1]) begin
				pre_x = a;
				pre_y = -b;
				pre_z = ZW'(Q30_HALF_PI);
			end else begin
				pre_x = -a;
				pre_y = b;
				pre_z = -ZW'(Q30_HALF_PI);
			end
		end
	end

	assign pre_xe = CW'(pre_x);
	assign pre_ye = CW'(pre_y);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0]    <= pre_xe <<< PRE_SHIFT;
			y_s[0]    <= pre_ye <<< PRE_SHIFT;
			z_s[0]    <= pre_z;
			zero_s[0] <= (a == '0) && (b == '0);
		end
	end

	// one micro-rotation per stage, driving y toward zero
	for (genvar i = 0; i < NUM_STAGES; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q30(i);
				end
				zero_s[i+1] <= zero_s[i];
			end
		end
	end

	logic signed [NUM_W-1:0] zmul_w;
	logic signed [NUM_W-1:0] num_w;
	logic signed [NUM_W-1:0] num_s1;
	logic [NUM_W-1:0]        mag_w;
	logic [NUM_W:0]          rnd_w;
	logic [T_W-1:0]          t_s2;
	logic                    neg_s2;
	logic [PROD_W-1:0]       prod_s3;
	logic                    neg_s3;
	logic [31:0]             q_w;
	logic [DEG_W-1:0]        r_w;
	deg_t                    deg_s4;

	// scale by 573, zero vector gives zero
	assign zmul_w = NUM_W'(z_s[NUM_STAGES]) * NUM_W'(DEG_SCALE);
	assign num_w  = zero_s[NUM_STAGES] ? '0 : zmul_w;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= num_w;
		end
	end

	// magnitude, round half away from zero, drop the binary part of the divisor
	assign mag_w = num_s1[NUM_W-1] ? NUM_W'(-num_s1) : NUM_W'(num_s1);
	assign rnd_w = {1'b0, mag_w} + ((NUM_W + 1)'(5) << ROUND_SHIFT);

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2   <= rnd_w[ROUND_SHIFT+T_W-1:ROUND_SHIFT];
			neg_s2 <= num_s1[NUM_W-1];
		end
	end

	// divide by ten through a reciprocal multiply
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= PROD_W'(t_s2) * PROD_W'(DIV10_M);
			neg_s3  <= neg_s2;
		end
	end

	// saturate and restore the sign
	assign q_w = 32'(prod_s3[PROD_W-1:DIV10_K]);
	assign r_w = (q_w > 32'(lim)) ? lim : q_w[DEG_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s4 <= neg_s3 ? -$signed(r_w) : $signed(r_w);
		end
	end

	assign deg = deg_s4;

endmodule

// ===== design/accel_tilt_roll_pitch.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch: roll and pitch in degrees from a three-axis sample
// From input accept to m_tvalid: 47 pipeline stages plus the output register.
// Throughput one item per cycle; a 2-entry output skid buffer stalls the pipeline.
// Async reset clears valid bits and the skid buffer; payload is not reset.
// ----------------------------------------------------------------------------
`include "accel_tilt_roll_pitch_assert.svh"

module accel_tilt_roll_pitch (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // roll_deg [16:0], pitch_deg [32:17], zero [39:33]
);
	import atrp_pkg::*;

	logic adv;
	logic [PIPE_DEPTH-1:0] v_q;

	// output skid buffer: head register plus one spare entry
	logic                      out_valid_q, spare_valid_q;
	logic signed [ROLL_W-1:0]  out_roll_q, spare_roll_q;
	logic signed [PITCH_W-1:0] out_pitch_q, spare_pitch_q;
	logic push, pop;

	logic signed [AXIS_W-1:0] x_in;
	logic signed [AXIS_W-1:0] y_in;
	logic signed [AXIS_W-1:0] z_in;
	logic signed [31:0]       yy_w;
	logic signed [31:0]       zz_w;

	logic signed [AXIS_W-1:0] x_s1, y_s1, z_s1;
	logic [30:0]              ysq_s1, zsq_s1;
	logic signed [AXIS_W-1:0] x_s2, y_s2, z_s2;
	logic [SQ_W-1:0]          sq_s2;

	logic signed [AXIS_W-1:0] x_dly_s [0:ISQRT_STAGES-1];
	logic signed [AXIS_W-1:0] y_dly_s [0:ISQRT_STAGES-1];
	logic signed [AXIS_W-1:0] z_dly_s [0:ISQRT_STAGES-1];

	root_t root;
	vec_t  roll_a, roll_b, pitch_a, pitch_b, x_neg;
	deg_t  roll_deg, pitch_full;

	// whole pipeline moves unless the skid buffer is full
	assign adv      = !spare_valid_q;
	assign s_tready = adv;

	assign x_in = s_tdata[15:0];
	assign y_in = s_tdata[31:16];
	assign z_in = s_tdata[47:32];

	// valid bits travel alongside the payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[PIPE_DEPTH-2:0], s_tvalid};
		end
	end

	// squares of y and z
	assign yy_w = 32'(y_in) * 32'(y_in);
	assign zz_w = 32'(z_in) * 32'(z_in);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= x_in;
			y_s1   <= y_in;
			z_s1   <= z_in;
			ysq_s1 <= yy_w[30:0];
			zsq_s1 <= zz_w[30:0];
		end
	end

	// sum of squares
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			z_s2  <= z_s1;
			sq_s2 <= {1'b0, ysq_s1} + {1'b0, zsq_s1};
		end
	end

	atrp_isqrt u_isqrt (
		.clk  (clk),
		.adv  (adv),
		.sq   (sq_s2),
		.root (root)
	);

	// raw axes wait alongside the square root
	always_ff @(posedge clk) begin
		if (adv) begin
			x_dly_s[0] <= x_s2;
			y_dly_s[0] <= y_s2;
			z_dly_s[0] <= z_s2;
			for (int i = 1; i < ISQRT_STAGES; i++) begin
				x_dly_s[i] <= x_dly_s[i-1];
				y_dly_s[i] <= y_dly_s[i-1];
				z_dly_s[i] <= z_dly_s[i-1];
			end
		end
	end

	// roll = atan2(y, z), pitch = atan2(-x * 2^8, root)
	assign roll_a  = AW'(y_dly_s[ISQRT_STAGES-1]);
	assign roll_b  = AW'(z_dly_s[ISQRT_STAGES-1]);
	assign x_neg   = -AW'(x_dly_s[ISQRT_STAGES-1]);
	assign pitch_a = x_neg <<< MAG_FRAC;
	assign pitch_b = {1'b0, root};

	atrp_atan_deg u_roll (
		.clk (clk),
		.adv (adv),
		.a   (roll_a),
		.b   (roll_b),
		.lim (DEG_W'(ROLL_LIM)),
		.deg (roll_deg)
	);

	atrp_atan_deg u_pitch (
		.clk (clk),
		.adv (adv),
		.a   (pitch_a),
		.b   (pitch_b),
		.lim (DEG_W'(PITCH_LIM)),
		.deg (pitch_full)
	);

	// skid buffer control
	assign push = adv && v_q[PIPE_DEPTH-1];
	assign pop  = out_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (spare_valid_q) begin
			if (pop) begin
				spare_valid_q <= 1'b0;
			end
		end else if (push) begin
			out_valid_q <= 1'b1;
			if (out_valid_q && !pop) begin
				spare_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (spare_valid_q) begin
			if (pop) begin
				out_roll_q  <= spare_roll_q;
				out_pitch_q <= spare_pitch_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_roll_q  <= roll_deg;
				out_pitch_q <= pitch_full[PITCH_W-1:0];
			end else begin
				spare_roll_q  <= roll_deg;
				spare_pitch_q <= pitch_full[PITCH_W-1:0];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_pitch_q, out_roll_q};

	// checks
	`ATRP_ASSERT(a_spare_implies_head, spare_valid_q |-> out_valid_q)
	`ATRP_ASSERT(a_head_drops_on_take, $fell(out_valid_q) |-> $past(m_tready))
	`ATRP_ASSERT(a_stall_holds_tail, (!s_tready && v_q[PIPE_DEPTH-1]) |=> v_q[PIPE_DEPTH-1])
	`ATRP_ASSERT_RST(a_reset_empty, !arst_n |=> (!out_valid_q && !spare_valid_q))

endmodule
